>>> rtl/core/lifn_pkg.sv
// Package for the leaky integrate-and-fire neuron update block.
// Holds field widths, register codes and reset values, pipeline stage types
// and the saturation helper. No dependencies.
`default_nettype none

package lifn_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int FAC_W     = 16;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Defaults for the top-level parameters
  localparam int NEURONS_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;

  // Product width: 33-bit signed value times 17-bit signed (zero-extended) factor
  localparam int PROD_W = VAL_W + FAC_W + 2;
  // Working width for sums before saturation
  localparam int WIDE_W = PROD_W + 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_REST_LEVEL    = 3'd1,
    CFG_LEAK_LEVEL    = 3'd2,
    CFG_TIME_STEP     = 3'd3,
    CFG_MEM_DECAY_EXC = 3'd4,
    CFG_MEM_DECAY_INH = 3'd5,
    CFG_SYN_DECAY_EXC = 3'd6,
    CFG_SYN_DECAY_INH = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic signed [VAL_W-1:0] THRESHOLD_RST     = 32'sd1310720;
  localparam logic signed [VAL_W-1:0] REST_LEVEL_RST    = 32'sd0;
  localparam logic signed [VAL_W-1:0] LEAK_LEVEL_RST    = 32'sd0;
  localparam logic [FAC_W-1:0]        TIME_STEP_RST     = 16'd66;
  localparam logic [FAC_W-1:0]        MEM_DECAY_EXC_RST = 16'd62000;
  localparam logic [FAC_W-1:0]        MEM_DECAY_INH_RST = 16'd60000;
  localparam logic [FAC_W-1:0]        SYN_DECAY_EXC_RST = 16'd55000;
  localparam logic [FAC_W-1:0]        SYN_DECAY_INH_RST = 16'd50000;

  // Per-neuron state word
  typedef struct packed {
    logic signed [VAL_W-1:0] voltage;
    logic signed [VAL_W-1:0] net_input;
    logic signed [VAL_W-1:0] exc_current;
    logic signed [VAL_W-1:0] inh_current;
    logic [CNT_W-1:0]        spike_count;
  } state_t;

  // Accepted input item
  typedef struct packed {
    logic [IDX_W-1:0]        neuron_index;
    logic                    population;
    logic signed [VAL_W-1:0] ff_input;
    logic signed [VAL_W-1:0] exc_increment;
    logic signed [VAL_W-1:0] inh_increment;
  } in_item_t;

  // After the sum stage
  typedef struct packed {
    logic [IDX_W-1:0]        idx;
    logic                    inr;
    logic                    population;
    logic signed [VAL_W-1:0] v_old;
    logic signed [VAL_W:0]   net_leak;
    logic signed [VAL_W-1:0] exc_sum;
    logic signed [VAL_W-1:0] inh_sum;
    logic signed [VAL_W-1:0] net_new;
    logic [CNT_W-1:0]        cnt_old;
  } sum_stage_t;

  // After the multiply stage
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     inr;
    logic signed [PROD_W-1:0] v_prod;
    logic signed [PROD_W-1:0] drive_prod;
    logic signed [PROD_W-1:0] exc_prod;
    logic signed [PROD_W-1:0] inh_prod;
    logic signed [VAL_W-1:0]  net_new;
    logic [CNT_W-1:0]         cnt_old;
  } mul_stage_t;

  // Finished update: state write-back and result item
  typedef struct packed {
    state_t                  wr_state;
    logic [IDX_W-1:0]        neuron_out;
    logic                    spike;
    logic signed [VAL_W-1:0] membrane;
    logic [CNT_W-1:0]        spike_total;
  } result_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    lo = {{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    if (x > hi) begin
      sat_val = hi[VAL_W-1:0];
    end else if (x < lo) begin
      sat_val = lo[VAL_W-1:0];
    end else begin
      sat_val = x[VAL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lifn_in_if.sv
// Input channel of the neuron update block: valid/ready plus the item fields.
// Depends on lifn_pkg.
`default_nettype none

interface lifn_in_if
  import lifn_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        neuron_index;
  logic                    population;
  logic signed [VAL_W-1:0] ff_input;
  logic signed [VAL_W-1:0] exc_increment;
  logic signed [VAL_W-1:0] inh_increment;

  modport source (
    output valid, neuron_index, population, ff_input, exc_increment, inh_increment,
    input  ready
  );

  modport sink (
    input  valid, neuron_index, population, ff_input, exc_increment, inh_increment,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/lifn_out_if.sv
// Result channel of the neuron update block: valid/ready plus the item fields.
// Depends on lifn_pkg.
`default_nettype none

interface lifn_out_if
  import lifn_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        neuron_out;
  logic                    spike;
  logic signed [VAL_W-1:0] membrane;
  logic [CNT_W-1:0]        spike_total;

  modport source (
    output valid, neuron_out, spike, membrane, spike_total,
    input  ready
  );

  modport sink (
    input  valid, neuron_out, spike, membrane, spike_total,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/lifn_state.sv
// Per-neuron state memory with registered read, write-back bypass and the
// clearing sweep after reset. Depends on lifn_pkg.
`default_nettype none

module lifn_state
  import lifn_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] rd_idx,
  input  wire logic [IDX_W-1:0] sel_idx,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire state_t           wr_data,
  output state_t                st,
  output logic                  busy
);

  localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NEURONS - 1);

  state_t             mem [NEURONS];
  state_t             rd_data_r;
  state_t             wb_data_r;
  logic [IDX_W-1:0]   wb_idx_r;
  logic               wb_valid_r;
  logic               clr_busy_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;

  assign rd_addr = ADDR_W'(rd_idx);
  assign wr_addr = ADDR_W'(wr_idx);

  // Clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // Memory array: one write port, one registered read port (read before write)
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Hold the entry written at the last edge; that read saw the old value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= wr_en & ~clr_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    wb_idx_r  <= wr_idx;
    wb_data_r <= wr_data;
  end

  assign st   = (wb_valid_r && wb_idx_r == sel_idx) ? wb_data_r : rd_data_r;
  assign busy = clr_busy_r;

endmodule

`default_nettype wire

>>> rtl/core/lifn_prep.sv
// Sum stage: saturating current and net-input sums and net input plus leak,
// registered into the multiply stage. Depends on lifn_pkg.
`default_nettype none

module lifn_prep
  import lifn_pkg::*;
#(
  parameter int NEURONS = NEURONS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire in_item_t                item,
  input  wire state_t                  st,
  input  wire logic signed [VAL_W-1:0] leak_level,
  output sum_stage_t                   sum_q
);

  sum_stage_t               sum_r;
  sum_stage_t               sum_nxt;
  logic signed [WIDE_W-1:0] exc_wide;
  logic signed [WIDE_W-1:0] inh_wide;
  logic signed [WIDE_W-1:0] ff_wide;
  logic signed [WIDE_W-1:0] net_wide;
  logic signed [VAL_W-1:0]  exc_sat;
  logic signed [VAL_W-1:0]  inh_sat;
  logic signed [VAL_W-1:0]  ff_sat;

  // Current sums, then net input = ff + exc + inh, each step saturating
  always_comb begin
    exc_wide = WIDE_W'(st.exc_current) + WIDE_W'(item.exc_increment);
    inh_wide = WIDE_W'(st.inh_current) + WIDE_W'(item.inh_increment);
    exc_sat  = sat_val(exc_wide);
    inh_sat  = sat_val(inh_wide);
    ff_wide  = WIDE_W'(item.ff_input) + WIDE_W'(exc_sat);
    ff_sat   = sat_val(ff_wide);
    net_wide = WIDE_W'(ff_sat) + WIDE_W'(inh_sat);

    sum_nxt.idx        = item.neuron_index;
    sum_nxt.inr        = ({{(32-IDX_W){1'b0}}, item.neuron_index} < 32'(NEURONS));
    sum_nxt.population = item.population;
    sum_nxt.v_old      = st.voltage;
    sum_nxt.net_leak   = $signed({st.net_input[VAL_W-1], st.net_input}) +
                         $signed({leak_level[VAL_W-1], leak_level});
    sum_nxt.exc_sum    = exc_sat;
    sum_nxt.inh_sum    = inh_sat;
    sum_nxt.net_new    = sat_val(net_wide);
    sum_nxt.cnt_old    = st.spike_count;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_q = sum_r;

endmodule

`default_nettype wire

>>> rtl/core/lifn_mult.sv
// Multiply stage: membrane decay, dt drive and both current decays, one
// multiplier each (at most 33x17 bits), registered. Depends on lifn_pkg.
`default_nettype none

module lifn_mult
  import lifn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire sum_stage_t       sum_in,
  input  wire logic [FAC_W-1:0] time_step,
  input  wire logic [FAC_W-1:0] mem_decay_exc,
  input  wire logic [FAC_W-1:0] mem_decay_inh,
  input  wire logic [FAC_W-1:0] syn_decay_exc,
  input  wire logic [FAC_W-1:0] syn_decay_inh,
  output mul_stage_t            mul_q
);

  mul_stage_t              mul_r;
  mul_stage_t              mul_nxt;
  logic signed [FAC_W:0]   mem_fac;
  logic signed [FAC_W:0]   dt_fac;
  logic signed [FAC_W:0]   exc_fac;
  logic signed [FAC_W:0]   inh_fac;

  // Factors are unsigned fractions; zero-extend to signed operands
  always_comb begin
    mem_fac = $signed({1'b0, (sum_in.population ? mem_decay_inh : mem_decay_exc)});
    dt_fac  = $signed({1'b0, time_step});
    exc_fac = $signed({1'b0, syn_decay_exc});
    inh_fac = $signed({1'b0, syn_decay_inh});

    mul_nxt.idx        = sum_in.idx;
    mul_nxt.inr        = sum_in.inr;
    mul_nxt.v_prod     = PROD_W'(sum_in.v_old) * PROD_W'(mem_fac);
    mul_nxt.drive_prod = PROD_W'(sum_in.net_leak) * PROD_W'(dt_fac);
    mul_nxt.exc_prod   = PROD_W'(sum_in.exc_sum) * PROD_W'(exc_fac);
    mul_nxt.inh_prod   = PROD_W'(sum_in.inh_sum) * PROD_W'(inh_fac);
    mul_nxt.net_new    = sum_in.net_new;
    mul_nxt.cnt_old    = sum_in.cnt_old;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r <= mul_nxt;
    end
  end

  assign mul_q = mul_r;

endmodule

`default_nettype wire

>>> rtl/core/lifn_finish.sv
// Finish stage: floor shifts, membrane integration, threshold test, spike
// count and the result item. Combinational. Depends on lifn_pkg.
`default_nettype none

module lifn_finish
  import lifn_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire mul_stage_t              mul_in,
  input  wire logic signed [VAL_W-1:0] threshold,
  input  wire logic signed [VAL_W-1:0] rest_level,
  output result_t                      res
);

  logic signed [WIDE_W-1:0] v_dec_wide;
  logic signed [WIDE_W-1:0] drive_wide;
  logic signed [WIDE_W-1:0] exc_wide;
  logic signed [WIDE_W-1:0] inh_wide;
  logic signed [WIDE_W-1:0] v_sum_wide;
  logic signed [VAL_W-1:0]  v_dec;
  logic signed [VAL_W-1:0]  v_sum;
  logic signed [VAL_W-1:0]  v_new;
  logic                     fire;
  logic [CNT_W-1:0]         cnt_new;

  always_comb begin
    // Arithmetic shift right is floor division by 2^FRAC_BITS
    v_dec_wide = WIDE_W'(mul_in.v_prod >>> FRAC_BITS);
    drive_wide = WIDE_W'(mul_in.drive_prod >>> FRAC_BITS);
    exc_wide   = WIDE_W'(mul_in.exc_prod >>> FRAC_BITS);
    inh_wide   = WIDE_W'(mul_in.inh_prod >>> FRAC_BITS);

    v_dec      = sat_val(v_dec_wide);
    v_sum_wide = WIDE_W'(v_dec) + drive_wide;
    v_sum      = sat_val(v_sum_wide);

    // Threshold crossing resets to rest and bumps the saturating count
    fire    = (v_sum >= threshold);
    v_new   = fire ? rest_level : v_sum;
    cnt_new = (fire && mul_in.cnt_old != CNT_MAX) ? mul_in.cnt_old + CNT_W'(1) :
                                                    mul_in.cnt_old;

    res.wr_state.voltage     = v_new;
    res.wr_state.net_input   = mul_in.net_new;
    res.wr_state.exc_current = sat_val(exc_wide);
    res.wr_state.inh_current = sat_val(inh_wide);
    res.wr_state.spike_count = cnt_new;

    // Out-of-range neuron: zero result, no state change
    res.neuron_out  = mul_in.idx;
    res.spike       = mul_in.inr & fire;
    res.membrane    = mul_in.inr ? v_new : '0;
    res.spike_total = mul_in.inr ? cnt_new : '0;
  end

endmodule

`default_nettype wire

>>> rtl/core/lif_neuron_update.sv
// Top level of the leaky integrate-and-fire neuron update block.
// Depends on lifn_pkg, lifn_in_if, lifn_out_if, lifn_state, lifn_prep,
// lifn_mult and lifn_finish.
`default_nettype none

// Each input item advances one neuron by one tick and gives one result item.
// The block takes one item per cycle unless the result channel stalls or an
// item waits; each item passes state read with the input register, sums,
// products and finish into the output register. Neuron state lives in one
// memory read-modify-written by the pipeline, so an item for a neuron that is
// still in the sum or multiply stage waits until that update is written back.
// After reset the state memory is cleared entry by entry, during which
// no item is accepted; configuration writes are taken at any time and must
// only be made while the block is idle. Indexes at or above NEURONS return a
// zero result and leave the state alone.
module lif_neuron_update
  import lifn_pkg::*;
#(
  parameter int NEURONS   = NEURONS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lifn_in_if.sink                   in_chan,
  lifn_out_if.source                out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_data
);

  // Configuration registers
  logic signed [VAL_W-1:0] threshold_r;
  logic signed [VAL_W-1:0] rest_level_r;
  logic signed [VAL_W-1:0] leak_level_r;
  logic [FAC_W-1:0]        time_step_r;
  logic [FAC_W-1:0]        mem_decay_exc_r;
  logic [FAC_W-1:0]        mem_decay_inh_r;
  logic [FAC_W-1:0]        syn_decay_exc_r;
  logic [FAC_W-1:0]        syn_decay_inh_r;

  // Pipeline control
  in_item_t         p1_r;
  logic             p1_valid_r;
  logic             p1_valid_nxt;
  logic             p2_valid_r;
  logic             p3_valid_r;
  logic             out_valid_r;
  result_t          out_r;
  sum_stage_t       p2;
  mul_stage_t       p3;
  result_t          res;
  state_t           st;
  in_item_t         in_item;
  logic             busy;
  logic             in_ready;
  logic             in_accept;
  logic             hazard;
  logic             p1_go;
  logic             p2_take;
  logic             en2;
  logic             en3;
  logic             p3_fire;
  logic [IDX_W-1:0] rd_idx;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RST;
      rest_level_r    <= REST_LEVEL_RST;
      leak_level_r    <= LEAK_LEVEL_RST;
      time_step_r     <= TIME_STEP_RST;
      mem_decay_exc_r <= MEM_DECAY_EXC_RST;
      mem_decay_inh_r <= MEM_DECAY_INH_RST;
      syn_decay_exc_r <= SYN_DECAY_EXC_RST;
      syn_decay_inh_r <= SYN_DECAY_INH_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD:     threshold_r     <= cfg_data;
        CFG_REST_LEVEL:    rest_level_r    <= cfg_data;
        CFG_LEAK_LEVEL:    leak_level_r    <= cfg_data;
        CFG_TIME_STEP:     time_step_r     <= cfg_data[FAC_W-1:0];
        CFG_MEM_DECAY_EXC: mem_decay_exc_r <= cfg_data[FAC_W-1:0];
        CFG_MEM_DECAY_INH: mem_decay_inh_r <= cfg_data[FAC_W-1:0];
        CFG_SYN_DECAY_EXC: syn_decay_exc_r <= cfg_data[FAC_W-1:0];
        CFG_SYN_DECAY_INH: syn_decay_inh_r <= cfg_data[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.neuron_index  = in_chan.neuron_index;
  assign in_item.population    = in_chan.population;
  assign in_item.ff_input      = in_chan.ff_input;
  assign in_item.exc_increment = in_chan.exc_increment;
  assign in_item.inh_increment = in_chan.inh_increment;

  // Stall chain: output register, finish, multiply, sum
  always_comb begin
    en3     = !out_valid_r || out_chan.ready;
    p3_fire = p3_valid_r && en3;
    en2     = !p3_valid_r || en3;
    p2_take = !p2_valid_r || en2;
    // Wait while an older update of the same neuron is not yet written back
    hazard  = (p2_valid_r && p2.inr && p2.idx == p1_r.neuron_index) ||
              (p3_valid_r && p3.inr && p3.idx == p1_r.neuron_index);
    p1_go   = p1_valid_r && !hazard && p2_take;
    in_ready  = !busy && (!p1_valid_r || p1_go);
    in_accept = in_chan.valid && in_ready;
    p1_valid_nxt = in_accept ? 1'b1 : (p1_go ? 1'b0 : p1_valid_r);
    // A held item re-reads its entry each cycle
    rd_idx = (p1_valid_r && !p1_go) ? p1_r.neuron_index : in_chan.neuron_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
      if (p2_take) begin
        p2_valid_r <= p1_go;
      end
      if (en2) begin
        p3_valid_r <= p2_valid_r;
      end
      if (en3) begin
        out_valid_r <= p3_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_r <= in_item;
    end
    if (p3_fire) begin
      out_r <= res;
    end
  end

  lifn_state #(
    .NEURONS (NEURONS)
  ) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .sel_idx (p1_r.neuron_index),
    .wr_en   (p3_fire && p3.inr),
    .wr_idx  (p3.idx),
    .wr_data (res.wr_state),
    .st      (st),
    .busy    (busy)
  );

  lifn_prep #(
    .NEURONS (NEURONS)
  ) u_prep (
    .clk        (clk),
    .en         (p1_go),
    .item       (p1_r),
    .st         (st),
    .leak_level (leak_level_r),
    .sum_q      (p2)
  );

  lifn_mult u_mult (
    .clk           (clk),
    .en            (en2),
    .sum_in        (p2),
    .time_step     (time_step_r),
    .mem_decay_exc (mem_decay_exc_r),
    .mem_decay_inh (mem_decay_inh_r),
    .syn_decay_exc (syn_decay_exc_r),
    .syn_decay_inh (syn_decay_inh_r),
    .mul_q         (p3)
  );

  lifn_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .mul_in     (p3),
    .threshold  (threshold_r),
    .rest_level (rest_level_r),
    .res        (res)
  );

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.neuron_out  = out_r.neuron_out;
  assign out_chan.spike       = out_r.spike;
  assign out_chan.membrane    = out_r.membrane;
  assign out_chan.spike_total = out_r.spike_total;

  // No item enters while the state memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready)
    else $error("item accepted during state clearing");

  // A spiking result always carries a nonzero count
  a_spike_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.spike) |-> (out_r.spike_total != '0))
    else $error("spike without count");

  // A held item is not dropped from the sum stage input
  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_valid_r && !p1_go) |=> (p1_valid_r && $stable(p1_r)))
    else $error("stalled item lost");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the leaky integrate-and-fire neuron update block.
// Depends on lifn_pkg, lifn_in_if, lifn_out_if and lif_neuron_update; it keeps
// its own copy of the neuron stores and predicts every result item.
`default_nettype none

module tb
  import lifn_pkg::*;
;

  localparam int NEURON_CNT    = NEURONS_DEF;
  localparam int FRAC          = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_MAX    = 10;
  localparam logic [VAL_W-1:0] VMAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VMIN = 32'h8000_0000;

  // One expected result item
  typedef struct packed {
    logic [IDX_W-1:0]        neuron_out;
    logic                    spike;
    logic signed [VAL_W-1:0] membrane;
    logic [CNT_W-1:0]        spike_total;
  } neuron_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_data;

  lifn_in_if  in_chan ();
  lifn_out_if out_chan ();

  lif_neuron_update dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Model copy of the registers
  logic signed [VAL_W-1:0] thr_q, rest_q, leak_q;
  logic [FAC_W-1:0]        dt_q, mdec_exc_q, mdec_inh_q, sdec_exc_q, sdec_inh_q;

  // Model copy of the per-neuron stores
  logic signed [VAL_W-1:0] volt_mem [NEURON_CNT];
  logic signed [VAL_W-1:0] net_mem  [NEURON_CNT];
  logic signed [VAL_W-1:0] exc_mem  [NEURON_CNT];
  logic signed [VAL_W-1:0] inh_mem  [NEURON_CNT];
  logic [CNT_W-1:0]        count_mem[NEURON_CNT];

  in_item_t       tick_queue[$];
  neuron_result_t results_due[$];
  in_item_t       offered;
  neuron_result_t due;
  int             mismatch_cnt;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_req;
  int             hold_seen;
  int             stall_left;

  // Clamp to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] clamp32(input longint x);
    if (x > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (x < -longint'(64'sd2147483648)) return 32'sh8000_0000;
    return x[VAL_W-1:0];
  endfunction

  // Value times unsigned fraction, floored, then clamped
  function automatic logic signed [VAL_W-1:0] scale(input logic signed [VAL_W-1:0] v,
                                                    input logic [FAC_W-1:0] f);
    longint a;
    longint b;
    a = longint'(v);
    b = longint'(f);
    return clamp32((a * b) >>> FRAC);
  endfunction

  // Advance one neuron by one tick and return the result it gives
  function automatic neuron_result_t advance_neuron(input in_item_t it);
    neuron_result_t r;
    int             n;
    logic signed [VAL_W-1:0] v, ce, ci, ff_net;
    longint net_l, leak_l, dt_l, drive, ff_l, ce_l, ci_l;
    r.neuron_out  = it.neuron_index;
    r.spike       = 1'b0;
    r.membrane    = '0;
    r.spike_total = '0;
    n = int'(it.neuron_index);
    if (n >= NEURON_CNT) return r;

    // membrane: decay, then integrate net input plus leak
    v      = scale(volt_mem[n], it.population ? mdec_inh_q : mdec_exc_q);
    net_l  = longint'(net_mem[n]);
    leak_l = longint'(leak_q);
    dt_l   = longint'(dt_q);
    drive  = ((net_l + leak_l) * dt_l) >>> FRAC;
    ff_l   = longint'(v);
    v      = clamp32(ff_l + drive);
    if (v >= thr_q) begin
      v       = rest_q;
      r.spike = 1'b1;
      if (count_mem[n] != CNT_MAX) count_mem[n] = count_mem[n] + CNT_W'(1);
    end
    volt_mem[n] = v;

    // synaptic currents and the next net input
    ce_l = longint'(exc_mem[n]);
    ce   = clamp32(ce_l + longint'(it.exc_increment));
    ci_l = longint'(inh_mem[n]);
    ci   = clamp32(ci_l + longint'(it.inh_increment));
    ff_l = longint'(it.ff_input);
    ce_l = longint'(ce);
    ci_l = longint'(ci);
    ff_net     = clamp32(ff_l + ce_l);
    ff_l       = longint'(ff_net);
    net_mem[n] = clamp32(ff_l + ci_l);
    exc_mem[n] = scale(ce, sdec_exc_q);
    inh_mem[n] = scale(ci, sdec_inh_q);

    r.membrane    = v;
    r.spike_total = count_mem[n];
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sender: offers items from the queue, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) results_due.push_back(advance_neuron(offered));
      if (!in_chan.valid || in_chan.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = tick_queue.pop_front();
          in_chan.valid         <= 1'b1;
          in_chan.neuron_index  <= offered.neuron_index;
          in_chan.population    <= offered.population;
          in_chan.ff_input      <= offered.ff_input;
          in_chan.exc_increment <= offered.exc_increment;
          in_chan.inh_increment <= offered.inh_increment;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen      <= hold_req;
      stall_left     <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (results_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected result: neuron %0d spike %0b membrane %0d count %0d",
                   out_chan.neuron_out, out_chan.spike, out_chan.membrane,
                   out_chan.spike_total);
      end else begin
        due = results_due.pop_front();
        if (out_chan.neuron_out !== due.neuron_out || out_chan.spike !== due.spike ||
            out_chan.membrane !== due.membrane || out_chan.spike_total !== due.spike_total)
        begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("result mismatch: exp neuron %0d spike %0b membrane %0d count %0d",
                     due.neuron_out, due.spike, due.membrane, due.spike_total);
            $display("                 got neuron %0d spike %0b membrane %0d count %0d",
                     out_chan.neuron_out, out_chan.spike, out_chan.membrane,
                     out_chan.spike_total);
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t r, input logic [VAL_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      CFG_THRESHOLD:     thr_q      = d;
      CFG_REST_LEVEL:    rest_q     = d;
      CFG_LEAK_LEVEL:    leak_q     = d;
      CFG_TIME_STEP:     dt_q       = d[FAC_W-1:0];
      CFG_MEM_DECAY_EXC: mdec_exc_q = d[FAC_W-1:0];
      CFG_MEM_DECAY_INH: mdec_inh_q = d[FAC_W-1:0];
      CFG_SYN_DECAY_EXC: sdec_exc_q = d[FAC_W-1:0];
      CFG_SYN_DECAY_INH: sdec_inh_q = d[FAC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [VAL_W-1:0] thr, rest, leak, dt,
                               input logic [VAL_W-1:0] mde, mdi, sde, sdi);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_REST_LEVEL, rest);
    write_reg(CFG_LEAK_LEVEL, leak);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_MEM_DECAY_EXC, mde);
    write_reg(CFG_MEM_DECAY_INH, mdi);
    write_reg(CFG_SYN_DECAY_EXC, sde);
    write_reg(CFG_SYN_DECAY_INH, sdi);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    @(posedge clk);
    send_idle_pct <= snd;
    recv_idle_pct <= rcv;
  endtask

  task automatic push_tick(input logic [IDX_W-1:0] idx, input logic pop,
                           input logic [VAL_W-1:0] ff, exc, inh);
    in_item_t it;
    it.neuron_index  = idx;
    it.population    = pop;
    it.ff_input      = ff;
    it.exc_increment = exc;
    it.inh_increment = inh;
    tick_queue.push_back(it);
  endtask

  // Mix of extremes, small values and full-width random words
  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(9))
      0:       return VMAX;
      1:       return VMIN;
      2:       return '0;
      3, 4, 5: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a few hot neurons so state builds up and neurons fire
  task automatic push_random(input int count);
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1:    idx = IDX_W'($urandom_range(NEURON_CNT - 1));
        2:       idx = IDX_W'($urandom_range(NEURON_CNT - 1, NEURON_CNT - 16));
        default: idx = IDX_W'($urandom_range(15));
      endcase
      push_tick(idx, 1'($urandom_range(1)), rand_val(), rand_val(), rand_val());
    end
  endtask

  task automatic drain();
    while (tick_queue.size() != 0 || in_chan.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus and phase sequencing
  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_chan.valid         = 1'b0;
    in_chan.neuron_index  = '0;
    in_chan.population    = 1'b0;
    in_chan.ff_input      = '0;
    in_chan.exc_increment = '0;
    in_chan.inh_increment = '0;
    out_chan.ready        = 1'b0;
    mismatch_cnt          = 0;
    hold_req              = 0;
    hold_seen             = 0;
    stall_left            = 0;
    send_idle_pct         = 20;
    recv_idle_pct         = 88;
    thr_q                 = THRESHOLD_RST;
    rest_q                = REST_LEVEL_RST;
    leak_q                = LEAK_LEVEL_RST;
    dt_q                  = TIME_STEP_RST;
    mdec_exc_q            = MEM_DECAY_EXC_RST;
    mdec_inh_q            = MEM_DECAY_INH_RST;
    sdec_exc_q            = SYN_DECAY_EXC_RST;
    sdec_inh_q            = SYN_DECAY_INH_RST;
    foreach (volt_mem[i]) begin
      volt_mem[i]  = '0;
      net_mem[i]   = '0;
      exc_mem[i]   = '0;
      inh_mem[i]   = '0;
      count_mem[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items on reset values: saturating sums, firing, negative floor,
    // same neuron back to back, edge indexes
    push_tick(12'd0, 1'b0, 32'h0, 32'h0, 32'h0);
    push_tick(12'd4095, 1'b1, VMAX, VMAX, VMAX);
    push_tick(12'd4095, 1'b1, VMIN, VMIN, VMIN);
    push_tick(12'd4095, 1'b0, VMAX, 32'h0, VMIN);
    push_tick(12'd1, 1'b0, VMAX, 32'h0, 32'h0);
    push_tick(12'd1, 1'b0, VMAX, 32'h0, 32'h0);
    push_tick(12'd2, 1'b1, 32'hffff_ffff, 32'h0, 32'h0);
    push_tick(12'd1, 1'b0, VMAX, 32'h0, 32'h0);
    push_tick(12'd2, 1'b1, 32'hffff_ffff, 32'h0, 32'h0);
    push_tick(12'd1, 1'b1, VMAX, 32'h0, 32'h0);
    push_tick(12'd3, 1'b0, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff);
    push_tick(12'd3, 1'b1, 32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000);
    push_tick(12'd4094, 1'b0, VMIN, VMIN, 32'h0);
    push_tick(12'd4094, 1'b1, VMIN, 32'h0, VMIN);
    push_tick(12'd4094, 1'b0, 32'h0, VMAX, VMAX);
    push_tick(12'haaa, 1'b1, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0001);
    push_tick(12'h555, 1'b0, 32'h7fff_fffe, 32'h0000_0001, 32'hffff_fffe);
    repeat (6) push_tick(12'd5, 1'b0, 32'h0100_0000, 32'h0010_0000, 32'hfff8_0000);
    drain();

    // Extreme setting: highest threshold, lowest rest, full dt and excitatory decays, zero inhibitory decays
    apply_setting(VMAX, VMIN, VMAX, 32'd65535, 32'd65535, 32'd0, 32'd65535, 32'd0);
    push_random(80);
    drain();

    // Opposite extremes, sender now idles more than the receiver
    set_idling(88, 20);
    apply_setting(32'h0, VMAX, VMIN, 32'd0, 32'd0, 32'd65535, 32'd0, 32'd65535);
    push_random(80);
    drain();

    // Random moderate setting
    apply_setting($urandom_range(32'h0040_0000), 32'h0 - $urandom_range(32'h0002_0000),
                  $urandom_range(32'h0001_0000) - 32'h0000_8000, $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535));
    push_random(80);
    drain();

    // Reset values again, no idling; receiver holds off so the pipe backs up
    set_idling(0, 0);
    apply_setting(THRESHOLD_RST, REST_LEVEL_RST, LEAK_LEVEL_RST, 32'(TIME_STEP_RST),
                  32'(MEM_DECAY_EXC_RST), 32'(MEM_DECAY_INH_RST), 32'(SYN_DECAY_EXC_RST),
                  32'(SYN_DECAY_INH_RST));
    push_random(80);
    @(posedge clk);
    hold_req <= hold_req + 1;
    drain();

    // Lowest threshold: every tick fires, one neuron hit back to back
    apply_setting(VMIN, $urandom(), $urandom(), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535));
    repeat (40) push_tick(12'd9, 1'($urandom_range(1)), rand_val(), rand_val(),
                          rand_val());
    drain();

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
